FILE: rtl/tlb_lru_pkg.sv
`timescale 1ns / 1ps
// shared constants for the fifo/lru translation buffer
// no dependencies; imported by tlb_fifo_lru_replacement_unit and its testbench
package tlb_lru_pkg;

  localparam int CmdW   = 2;
  localparam int PageW  = 20;
  localparam int FrameW = 20;
  localparam int SlotW  = 4;
  localparam int RankW  = 4;
  localparam int ActW   = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  localparam int EntriesDef  = 16;
  localparam int PageBitsDef = 20;

  localparam logic [RankW-1:0] RankMax = '1;
  localparam logic [ActW-1:0]  ActiveReset = ActW'(16);

  // request commands
  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd1;
  localparam logic [CmdW-1:0] CMD_FLUSH  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_POLICY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE = 2'd1;

  // replacement policies
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

endpackage

FILE: rtl/tlb_fifo_lru_replacement_unit.sv
`timescale 1ns / 1ps
// fully associative tlb with fifo or lru replacement, one sequencer scanning the entries
// depends on tlb_lru_pkg
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------
//  in      | in_valid_i / in_stall_o   | cmd_i, page_i, frame_i
//  out     | out_valid_o / out_stall_i | hit_o, frame_out_o, slot_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a lookup scans up to n active entries (n = active entries), an lru hit adds a pass over
// all ENTRIES for rank aging; an insert scans the n active entries, then ages all ENTRIES. the
// scan is set by the single read port of the entry memories, visited once per cycle.
// flush and unknown commands skip the scan. reset clears valid bits and the fifo
// pointer at once, no clearing pass. in_stall_o is high while a request is in work;
// a finished result waits in the output register while the next request is taken.
module tlb_fifo_lru_replacement_unit #(
  parameter int ENTRIES   = tlb_lru_pkg::EntriesDef,
  parameter int PAGE_BITS = tlb_lru_pkg::PageBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tlb_lru_pkg::CmdW-1:0]   cmd_i,
  input  logic [tlb_lru_pkg::PageW-1:0]  page_i,
  input  logic [tlb_lru_pkg::FrameW-1:0] frame_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic [tlb_lru_pkg::FrameW-1:0] frame_out_o,
  output logic [tlb_lru_pkg::SlotW-1:0]  slot_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tlb_lru_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tlb_lru_pkg::CfgDataW-1:0] cfg_data_i
);
  import tlb_lru_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW = $clog2(ENTRIES + 1);
  localparam int TagW = (PAGE_BITS < PageW) ? PAGE_BITS : PageW;
  localparam logic [CntW-1:0] EntCnt = CntW'(ENTRIES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_AGE    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // control
  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]    rd_idx_q, rd_idx_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic               policy_q, policy_d;
  logic [ActW-1:0]    active_q, active_d;
  logic               found_q, found_d;
  logic               out_valid_q, out_valid_d;

  // request payload and scan results
  logic [CmdW-1:0]    cmd_q, cmd_d;
  logic [TagW-1:0]    page_q, page_d;
  logic [FrameW-1:0]  frm_q, frm_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [IdxW-1:0]    sel_idx_q, sel_idx_d;
  logic [RankW-1:0]   sel_rank_q, sel_rank_d;
  logic [IdxW-1:0]    max_idx_q, max_idx_d;
  logic [RankW-1:0]   max_rank_q, max_rank_d;
  logic [IdxW-1:0]    vic_idx_q, vic_idx_d;
  logic [RankW-1:0]   vic_rank_q, vic_rank_d;
  logic [IdxW-1:0]    tgt_q, tgt_d;
  logic [RankW-1:0]   old_q, old_d;
  logic               old_inf_q, old_inf_d;
  logic               res_hit_q, res_hit_d;
  logic [FrameW-1:0]  res_frame_q, res_frame_d;
  logic [SlotW-1:0]   res_slot_q, res_slot_d;
  logic               hit_q, hit_d;
  logic [FrameW-1:0]  frame_out_q, frame_out_d;
  logic [SlotW-1:0]   slot_q, slot_d;

  // entry memories
  logic [TagW-1:0]    tag_mem_q   [ENTRIES];
  logic [FrameW-1:0]  frame_mem_q [ENTRIES];
  logic [RankW-1:0]   rank_mem_q  [ENTRIES];
  logic [TagW-1:0]    tag_rd_q;
  logic [FrameW-1:0]  frame_rd_q;
  logic [RankW-1:0]   rank_rd_q;

  logic               issue;
  logic [CntW-1:0]    limit;
  logic               last;
  logic               tag_match;
  logic [CntW-1:0]    n_calc;
  logic [IdxW-1:0]    vic_calc;
  logic [IdxW-1:0]    adv;
  logic [RankW-1:0]   rank_new;
  logic               tf_we;
  logic               rk_we;
  logic               in_acc;
  logic               out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign frame_out_o = frame_out_q;
  assign slot_o      = slot_q;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // active count, clamped to 1..ENTRIES
  always_comb begin
    if (active_q == '0) begin
      n_calc = CntW'(1);
    end else if (32'(active_q) > 32'(ENTRIES)) begin
      n_calc = EntCnt;
    end else begin
      n_calc = CntW'(active_q);
    end
  end

  assign vic_calc  = (CntW'(ptr_q) < n_calc) ? ptr_q : '0;
  assign adv       = ((CntW'(vic_idx_q) + CntW'(1)) >= n_q) ? '0 : vic_idx_q + IdxW'(1);
  assign limit     = (state_q == S_AGE) ? EntCnt : n_q;
  assign issue     = ((state_q == S_SCAN) || (state_q == S_AGE)) && (idx_q < limit);
  assign last      = (CntW'(rd_idx_q) + CntW'(1)) == limit;
  assign tag_match = valid_q[rd_idx_q] && (tag_rd_q == page_q);

  // aging: entries more recent than the one promoted move back by one
  always_comb begin
    if (rd_idx_q == tgt_q) begin
      rank_new = '0;
    end else if (valid_q[rd_idx_q] && (old_inf_q || (rank_rd_q < old_q)) &&
                 (rank_rd_q != RankMax)) begin
      rank_new = rank_rd_q + RankW'(1);
    end else begin
      rank_new = rank_rd_q;
    end
  end

  assign rk_we = (state_q == S_AGE) && rd_pend_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = idx_q[IdxW-1:0];
    valid_d     = valid_q;
    ptr_d       = ptr_q;
    policy_d    = policy_q;
    active_d    = active_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    page_d      = page_q;
    frm_d       = frm_q;
    n_d         = n_q;
    sel_idx_d   = sel_idx_q;
    sel_rank_d  = sel_rank_q;
    max_idx_d   = max_idx_q;
    max_rank_d  = max_rank_q;
    vic_idx_d   = vic_idx_q;
    vic_rank_d  = vic_rank_q;
    tgt_d       = tgt_q;
    old_d       = old_q;
    old_inf_d   = old_inf_q;
    res_hit_d   = res_hit_q;
    res_frame_d = res_frame_q;
    res_slot_d  = res_slot_q;
    hit_d       = hit_q;
    frame_out_d = frame_out_q;
    slot_d      = slot_q;
    tf_we       = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POLICY: policy_d = cfg_data_i[0];
        CFG_ACTIVE: active_d = cfg_data_i[ActW-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d       = cmd_i;
          page_d      = page_i[TagW-1:0];
          frm_d       = frame_i;
          n_d         = n_calc;
          vic_idx_d   = vic_calc;
          idx_d       = '0;
          found_d     = 1'b0;
          res_hit_d   = 1'b0;
          res_frame_d = '0;
          res_slot_d  = '0;
          unique case (cmd_i) inside
            CMD_LOOKUP, CMD_INSERT: state_d = S_SCAN;
            CMD_FLUSH: begin
              valid_d = '0;
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_pend_d = 1'b1;
          idx_d     = idx_q + CntW'(1);
        end
        if (rd_pend_q) begin
          if (cmd_q == CMD_LOOKUP) begin
            if (tag_match) begin
              found_d     = 1'b1;
              sel_idx_d   = rd_idx_q;
              sel_rank_d  = rank_rd_q;
              res_frame_d = frame_rd_q;
            end
          end else begin
            if (!valid_q[rd_idx_q] && !found_q) begin
              found_d   = 1'b1;
              sel_idx_d = rd_idx_q;
            end
            // strict compare keeps the lowest index on a tie
            if ((rd_idx_q == '0) || (rank_rd_q > max_rank_q)) begin
              max_idx_d  = rd_idx_q;
              max_rank_d = rank_rd_q;
            end
            if (rd_idx_q == vic_idx_q) begin
              vic_rank_d = rank_rd_q;
            end
          end
          if (last || ((cmd_q == CMD_LOOKUP) && tag_match)) begin
            rd_pend_d = 1'b0;
            state_d   = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        idx_d = '0;
        if (cmd_q == CMD_INSERT) begin
          if (found_q) begin
            tgt_d     = sel_idx_q;
            old_inf_d = 1'b1;
          end else if (policy_q == POLICY_LRU) begin
            tgt_d     = max_idx_q;
            old_d     = max_rank_q;
            old_inf_d = 1'b0;
          end else begin
            tgt_d     = vic_idx_q;
            old_d     = vic_rank_q;
            old_inf_d = 1'b0;
            ptr_d     = adv;
          end
          tf_we          = 1'b1;
          valid_d[tgt_d] = 1'b1;
          res_slot_d     = SlotW'(tgt_d);
          state_d        = S_AGE;
        end else if (found_q) begin
          res_hit_d  = 1'b1;
          res_slot_d = SlotW'(sel_idx_q);
          if (policy_q == POLICY_LRU) begin
            tgt_d     = sel_idx_q;
            old_d     = sel_rank_q;
            old_inf_d = 1'b0;
            state_d   = S_AGE;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_AGE: begin
        if (issue) begin
          rd_pend_d = 1'b1;
          idx_d     = idx_q + CntW'(1);
        end
        if (rd_pend_q && last) begin
          rd_pend_d = 1'b0;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hit_d       = res_hit_q;
          frame_out_d = res_frame_q;
          slot_d      = res_slot_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      valid_q     <= '0;
      ptr_q       <= '0;
      policy_q    <= POLICY_FIFO;
      active_q    <= ActiveReset;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      valid_q     <= valid_d;
      ptr_q       <= ptr_d;
      policy_q    <= policy_d;
      active_q    <= active_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    cmd_q       <= cmd_d;
    page_q      <= page_d;
    frm_q       <= frm_d;
    n_q         <= n_d;
    sel_idx_q   <= sel_idx_d;
    sel_rank_q  <= sel_rank_d;
    max_idx_q   <= max_idx_d;
    max_rank_q  <= max_rank_d;
    vic_idx_q   <= vic_idx_d;
    vic_rank_q  <= vic_rank_d;
    tgt_q       <= tgt_d;
    old_q       <= old_d;
    old_inf_q   <= old_inf_d;
    res_hit_q   <= res_hit_d;
    res_frame_q <= res_frame_d;
    res_slot_q  <= res_slot_d;
    hit_q       <= hit_d;
    frame_out_q <= frame_out_d;
    slot_q      <= slot_d;
  end

  // one write and one registered read per cycle on each entry memory
  always_ff @(posedge clk_i) begin
    if (tf_we) begin
      tag_mem_q[tgt_d]   <= page_q;
      frame_mem_q[tgt_d] <= frm_q;
    end
    if (rk_we) begin
      rank_mem_q[rd_idx_q] <= rank_new;
    end
    if (issue) begin
      tag_rd_q   <= tag_mem_q[idx_q[IdxW-1:0]];
      frame_rd_q <= frame_mem_q[idx_q[IdxW-1:0]];
      rank_rd_q  <= rank_mem_q[idx_q[IdxW-1:0]];
    end
  end

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (cmd_i == CMD_FLUSH)) |=> (valid_q == '0))
    else $error("flush did not clear valid bits");

  a_miss_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (frame_out_o == '0))
    else $error("frame reported without a hit");

  a_pipe_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rd_pend_q)
    else $error("memory read left pending at idle");

endmodule

FILE: dv/tb_tlb_fifo_lru_replacement_unit.sv
`timescale 1ns / 1ps
// testbench for tlb_fifo_lru_replacement_unit: directed and random lookups, inserts and flushes
// under fifo and lru policies, checked against an in-bench translation buffer predictor
// depends on tlb_lru_pkg and the rtl of tlb_fifo_lru_replacement_unit
module tb_tlb_fifo_lru_replacement_unit;
  import tlb_lru_pkg::*;

  localparam logic [CmdW-1:0]    CMD_NOP     = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_RSVD_A  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RSVD_B  = 2'd3;
  localparam int                 CycleLimit  = 500_000;
  localparam int                 SettleCycles = 50;

  typedef struct packed {
    logic              hit;
    logic [FrameW-1:0] frame;
    logic [SlotW-1:0]  slot;
  } xlat_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i;
  logic [PageW-1:0]    page_i;
  logic [FrameW-1:0]   frame_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                hit_o;
  logic [FrameW-1:0]   frame_out_o;
  logic [SlotW-1:0]    slot_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // predictor state
  logic              ent_valid [EntriesDef];
  logic [PageW-1:0]  ent_page  [EntriesDef];
  logic [FrameW-1:0] ent_frame [EntriesDef];
  logic [RankW-1:0]  ent_rank  [EntriesDef];
  logic [SlotW-1:0]  fifo_ptr;
  logic              policy;
  logic [ActW-1:0]   active_cfg;

  xlat_result_t pending_results[$];
  logic         last_hit_pred;
  int           fail_count;
  int           result_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_left;

  tlb_fifo_lru_replacement_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .page_i      (page_i),
    .frame_i     (frame_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .frame_out_o (frame_out_o),
    .slot_o      (slot_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned active_count();
    int unsigned n;
    n = active_cfg;
    if (n == 0) n = 1;
    if (n > EntriesDef) n = EntriesDef;
    return n;
  endfunction

  // entry e becomes most recent, the ones that were more recent age by one
  function automatic void promote(int unsigned e);
    int unsigned prev;
    prev = ent_valid[e] ? int'(ent_rank[e]) : RankMax + 1;
    for (int unsigned i = 0; i < EntriesDef; i++) begin
      if (i != e && ent_valid[i] && ent_rank[i] < prev && ent_rank[i] < RankMax)
        ent_rank[i] = ent_rank[i] + 1'b1;
    end
    ent_rank[e] = '0;
  endfunction

  function automatic int unsigned pick_victim(int unsigned n);
    int unsigned v;
    v = 0;
    if (policy == POLICY_FIFO) begin
      v = (fifo_ptr < n) ? int'(fifo_ptr) : 0;
      fifo_ptr = (v + 1 >= n) ? '0 : SlotW'(v + 1);
    end else begin
      for (int unsigned i = 1; i < n; i++)
        if (ent_rank[i] > ent_rank[v]) v = i;
    end
    return v;
  endfunction

  function automatic xlat_result_t translate_and_update(logic [CmdW-1:0] c,
                                                        logic [PageW-1:0] p,
                                                        logic [FrameW-1:0] f);
    xlat_result_t r;
    int unsigned  n;
    int unsigned  target;
    r = '0;
    n = active_count();
    case (c)
      CMD_LOOKUP: begin
        for (int unsigned i = 0; i < n; i++) begin
          if (ent_valid[i] && ent_page[i] == p) begin
            r.hit   = 1'b1;
            r.frame = ent_frame[i];
            r.slot  = SlotW'(i);
            if (policy == POLICY_LRU) promote(i);
            break;
          end
        end
      end
      CMD_INSERT: begin
        target = n;
        for (int unsigned i = 0; i < n; i++) begin
          if (!ent_valid[i]) begin
            target = i;
            break;
          end
        end
        if (target == n) target = pick_victim(n);
        promote(target);
        ent_page[target]  = p;
        ent_frame[target] = f;
        ent_valid[target] = 1'b1;
        r.slot = SlotW'(target);
      end
      CMD_FLUSH: begin
        for (int unsigned i = 0; i < EntriesDef; i++) ent_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] result %0d %s: got 0x%0h expected 0x%0h", $realtime, result_count, what,
             got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin : check_result
    xlat_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("with no request waiting", {hit_o, frame_out_o, slot_o}, '0);
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (frame_out_o !== want.frame) report_mismatch("frame", frame_out_o, want.frame);
        if (slot_o !== want.slot) report_mismatch("slot", slot_o, want.slot);
      end
      result_count++;
    end
  end

  // receiver side: random stalls, or a long hold-off when asked for
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_request(logic [CmdW-1:0] c, logic [PageW-1:0] p, logic [FrameW-1:0] f);
    xlat_result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    page_i     <= p;
    frame_i    <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = translate_and_update(c, p, f);
    last_hit_pred = r.hit;
    pending_results.push_back(r);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_POLICY) policy = data[0];
    else if (idx == CFG_ACTIVE) active_cfg = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_policy(logic pol);
    logic [CfgDataW-1:0] data;
    data    = CfgDataW'($urandom_range(31));
    data[0] = pol;
    write_config(CFG_POLICY, data);
  endtask

  // mostly lookups that refill on a miss, over a small set of pages, plus noise
  task automatic run_traffic(int count, int pool_size);
    logic [PageW-1:0] pool[$];
    logic [PageW-1:0] pg;
    int               sent;
    int               r;
    sent = 0;
    for (int i = 0; i < pool_size; i++) pool.push_back(PageW'($urandom()));
    while (sent < count) begin
      r  = $urandom_range(99);
      pg = pool[$urandom_range(pool_size - 1)];
      if (r < 60) begin
        send_request(CMD_LOOKUP, pg, FrameW'($urandom()));
        sent++;
        if (!last_hit_pred) begin
          send_request(CMD_INSERT, pg, FrameW'($urandom()));
          sent++;
        end
      end else if (r < 85) begin
        send_request(CMD_INSERT, pg, FrameW'($urandom()));
        sent++;
      end else if (r < 92) begin
        send_request(CMD_LOOKUP, PageW'($urandom()), FrameW'($urandom()));
        sent++;
      end else if (r < 96) begin
        send_request(CMD_INSERT, PageW'($urandom()), FrameW'($urandom()));
        sent++;
      end else if (r < 98) begin
        send_request(CMD_FLUSH, PageW'($urandom()), FrameW'($urandom()));
        sent++;
      end else begin
        send_request(CMD_NOP, PageW'($urandom()), FrameW'($urandom()));
        sent++;
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_basic_ops();
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_INSERT, '0, '1);
    send_request(CMD_INSERT, '1, '0);
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_LOOKUP, '1, '1);
    // same page twice: lookup must report the lower slot
    send_request(CMD_INSERT, '0, 20'h12345);
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_NOP, '1, '1);
    send_request(CMD_FLUSH, '1, '1);
    send_request(CMD_LOOKUP, '1, '0);
    wait_idle();
  endtask

  task automatic test_config_edges();
    // zero active entries behaves as one
    write_config(CFG_ACTIVE, '0);
    send_request(CMD_INSERT, 20'hA0A0A, 20'h11111);
    send_request(CMD_INSERT, 20'h5F5F5, 20'h22222);
    send_request(CMD_LOOKUP, 20'hA0A0A, '0);
    send_request(CMD_LOOKUP, 20'h5F5F5, '0);
    wait_idle();
    // above the built depth saturates, unused indexes are ignored
    write_config(CFG_ACTIVE, '1);
    write_config(CFG_RSVD_A, '1);
    write_config(CFG_RSVD_B, '1);
    send_request(CMD_INSERT, 20'h33333, 20'h44444);
    send_request(CMD_LOOKUP, 20'h33333, '0);
    send_request(CMD_FLUSH, '0, '0);
    wait_idle();
    // pointer left beyond a shrunk active range, entries above it kept
    write_config(CFG_ACTIVE, ActW'(4));
    for (int i = 0; i < 7; i++) send_request(CMD_INSERT, PageW'(20'hC0000 + i), FrameW'(i));
    wait_idle();
    write_config(CFG_ACTIVE, ActW'(2));
    send_request(CMD_INSERT, 20'hD0000, 20'hFEDCB);
    send_request(CMD_LOOKUP, 20'hC0003, '0);
    wait_idle();
    write_config(CFG_ACTIVE, ActW'(4));
    send_request(CMD_LOOKUP, 20'hC0003, '0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    hold_left = 300;
    for (int i = 0; i < 10; i++)
      send_request((i % 2) ? CMD_LOOKUP : CMD_INSERT, PageW'(20'hE0000 + i / 2),
                   FrameW'($urandom()));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic ph_pol    [9] = '{POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_LRU,
                            POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_LRU};
    int   ph_active [9] = '{16, 16, 5, 4, 1, 0, 31, 17, 11};
    int   ph_pool   [9] = '{24, 24, 8, 6, 3, 3, 20, 20, 14};
    int   ph_items  [9] = '{140, 140, 120, 120, 100, 100, 130, 130, 120};
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle_pct  = 8;
        recv_stall_pct = 47;
      end else if (ph < 6) begin
        send_idle_pct  = 47;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      set_policy(ph_pol[ph]);
      write_config(CFG_ACTIVE, ActW'(ph_active[ph]));
      run_traffic(ph_items[ph], ph_pool[ph]);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_LOOKUP;
    page_i         = '0;
    frame_i        = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_POLICY;
    cfg_data_i     = '0;
    fail_count     = 0;
    result_count   = 0;
    cycle_count    = 0;
    hold_left      = 0;
    last_hit_pred  = 1'b0;
    send_idle_pct  = 8;
    recv_stall_pct = 47;
    for (int i = 0; i < EntriesDef; i++) begin
      ent_valid[i] = 1'b0;
      ent_page[i]  = '0;
      ent_frame[i] = '0;
      ent_rank[i]  = '0;
    end
    fifo_ptr   = '0;
    policy     = POLICY_FIFO;
    active_cfg = ActiveReset;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    test_config_edges();
    test_output_backpressure();
    test_random_traffic();

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tlb_lru_pkg.sv
rtl/tlb_fifo_lru_replacement_unit.sv
dv/tb_tlb_fifo_lru_replacement_unit.sv
